/* src/bts_pkg.sv */
// ----------------------------------------------------------------------------
// bts_pkg: shared types and constants of the bilinear texture sampler
// Texture size limits, derived widths and the pipeline control word.
// ----------------------------------------------------------------------------
package bts_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int AW         = XW + YW;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ONE_FIX    = 65536;

    // Unsigned 1.16 coordinate after clamping.
    typedef logic [16:0] coord_t;
    typedef logic [AW-1:0] addr_t;
    typedef logic [23:0] texel_t;

    // Control word that travels with every stage.
    typedef struct packed {
        logic valid;
        logic sample;
    } ctl_t;

    // Clamp a signed 2.16 coordinate to 0..1.0.
    function automatic coord_t clamp_coord(input logic [17:0] raw);
        coord_t res;
        if (raw[17])
        begin
            res = '0;
        end
        else if (raw[16:0] > 17'(ONE_FIX))
        begin
            res = 17'(ONE_FIX);
        end
        else
        begin
            res = raw[16:0];
        end
        return res;
    endfunction

endpackage

/* src/bilinear_texture_sampler.sv */
// ----------------------------------------------------------------------------
// bilinear_texture_sampler: RGB texture store with bilinear sampling
// Loads texels into an on-chip texture and returns bilinearly filtered
// colors for sample coordinates, one beat per clock.
// ----------------------------------------------------------------------------
// The sampler accepts one beat per clock and runs it through a six-stage
// pipeline: clamp, scale, address, texel read, row blend, and column blend
// with rounding. A sample beat yields one output beat at the end of the
// pipeline, a load beat yields none. The texture is held as four copies, one
// per corner of the filter footprint, so the four texel reads of a sample
// come from separate memory ports in one cycle; a load writes all four
// copies in the read stage, so beats always see earlier loads and never later
// ones. Texels that were never loaded read as arbitrary data. The whole
// pipeline advances whenever the output register is empty or being taken,
// so s_tready falls only while a result waits on m_tready. Width and height
// registers must be written while the pipeline is empty.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // load_address[15:0], load_red[23:16], load_green[31:24],
    // load_blue[39:32], coord_u[57:40], coord_v[75:58], zero pad [79:76]
    input  logic [79:0]  s_tdata,
    // operation[0]
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [23:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [8:0]   cfg_data
);

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;

    logic [8:0]      tex_width_reg, tex_height_reg;
    logic            en;
    bts_pkg::ctl_t   in_ctl, ctl3, ctl4, ctl6;
    logic [15:0]     la3;
    bts_pkg::texel_t lt3, ld_texel;
    bts_pkg::addr_t  a00, a10, a01, a11;
    logic [15:0]     fx3, fy3, fx4, fy4;
    bts_pkg::texel_t t00, t10, t01, t11, rgb;

    // Configuration registers; always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= 9'd256;
            tex_height_reg <= 9'd256;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_WIDTH:  tex_width_reg  <= cfg_data;
                REG_HEIGHT: tex_height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Global advance: the output register is free or being drained.
    assign en       = !(ctl6.valid && ctl6.sample) || m_tready;
    assign s_tready = en;

    assign in_ctl.valid  = s_tvalid;
    assign in_ctl.sample = s_tuser[0];
    // Stored texel layout is R in the top byte, B in the bottom byte.
    assign ld_texel = {s_tdata[23:16], s_tdata[31:24], s_tdata[39:32]};

    bts_addr u_addr (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .in_ctl           (in_ctl),
        .load_address     (s_tdata[15:0]),
        .load_texel       (ld_texel),
        .coord_u          (s_tdata[57:40]),
        .coord_v          (s_tdata[75:58]),
        .tex_width        (tex_width_reg),
        .tex_height       (tex_height_reg),
        .out_ctl          (ctl3),
        .out_load_address (la3),
        .out_load_texel   (lt3),
        .a00              (a00),
        .a10              (a10),
        .a01              (a01),
        .a11              (a11),
        .fx               (fx3),
        .fy               (fy3)
    );

    bts_texmem u_texmem (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_ctl       (ctl3),
        .load_address (la3),
        .load_texel   (lt3),
        .a00          (a00),
        .a10          (a10),
        .a01          (a01),
        .a11          (a11),
        .fx           (fx3),
        .fy           (fy3),
        .out_ctl      (ctl4),
        .t00          (t00),
        .t10          (t10),
        .t01          (t01),
        .t11          (t11),
        .out_fx       (fx4),
        .out_fy       (fy4)
    );

    bts_blend u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_ctl  (ctl4),
        .t00     (t00),
        .t10     (t10),
        .t01     (t01),
        .t11     (t11),
        .fx      (fx4),
        .fy      (fy4),
        .out_ctl (ctl6),
        .texel   (rgb)
    );

    assign m_tvalid = ctl6.valid && ctl6.sample;
    assign m_tdata  = {rgb[7:0], rgb[15:8], rgb[23:16]};

endmodule

/* src/bts_addr.sv */
// ----------------------------------------------------------------------------
// bts_addr: coordinate and address pipeline
// Clamps coordinates and sizes, scales by size-1 and forms four texel
// addresses with their blend weights over three register stages.
// ----------------------------------------------------------------------------
module bts_addr (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  bts_pkg::ctl_t        in_ctl,
    input  logic [15:0]          load_address,
    input  bts_pkg::texel_t      load_texel,
    input  logic [17:0]          coord_u,
    input  logic [17:0]          coord_v,
    input  logic [8:0]           tex_width,
    input  logic [8:0]           tex_height,
    output bts_pkg::ctl_t        out_ctl,
    output logic [15:0]          out_load_address,
    output bts_pkg::texel_t      out_load_texel,
    output bts_pkg::addr_t       a00,
    output bts_pkg::addr_t       a10,
    output bts_pkg::addr_t       a01,
    output bts_pkg::addr_t       a11,
    output logic [15:0]          fx,
    output logic [15:0]          fy
);

    localparam int XW = bts_pkg::XW;
    localparam int YW = bts_pkg::YW;
    localparam int AW = bts_pkg::AW;

    bts_pkg::ctl_t   ctl1_reg, ctl2_reg, ctl3_reg;
    logic [15:0]     la1_reg, la2_reg, la3_reg;
    bts_pkg::texel_t lt1_reg, lt2_reg, lt3_reg;
    bts_pkg::coord_t uc_reg, vc_reg;
    logic [XW:0]     wc_reg, wc2_reg;
    logic [XW-1:0]   wm1_reg;
    logic [YW-1:0]   hm1_reg;
    logic [16+XW:0]  tx_reg;
    logic [16+YW:0]  ty_reg;
    bts_pkg::addr_t  a00_reg, a10_reg, a01_reg, a11_reg;
    logic [15:0]     fx_reg, fy_reg;

    logic [XW:0]     wc_next;
    logic [YW:0]     hc_next;
    logic [XW-1:0]   x0, x1;
    logic [YW-1:0]   y0, y1;
    logic [15:0]     fx_next, fy_next;
    logic [AW+XW:0]  row0, row1;

    always_comb
    begin
        if (tex_width == 9'd0)
            wc_next = (XW+1)'(1);
        else if (32'(tex_width) > bts_pkg::MAX_WIDTH)
            wc_next = (XW+1)'(bts_pkg::MAX_WIDTH);
        else
            wc_next = (XW+1)'(tex_width);
        if (tex_height == 9'd0)
            hc_next = (YW+1)'(1);
        else if (32'(tex_height) > bts_pkg::MAX_HEIGHT)
            hc_next = (YW+1)'(bts_pkg::MAX_HEIGHT);
        else
            hc_next = (YW+1)'(tex_height);
    end

    always_comb
    begin
        fx_next = tx_reg[15:0];
        fy_next = ty_reg[15:0];
        x0      = tx_reg[16 +: XW];
        y0      = ty_reg[16 +: YW];
        x1      = x0 + XW'(fx_next != 16'd0);
        y1      = y0 + YW'(fy_next != 16'd0);
        row0    = (AW+XW+1)'(y0 * wc2_reg);
        row1    = (AW+XW+1)'(y1 * wc2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage 1: clamp.
            la1_reg <= load_address;
            lt1_reg <= load_texel;
            uc_reg  <= bts_pkg::clamp_coord(coord_u);
            vc_reg  <= bts_pkg::clamp_coord(coord_v);
            wc_reg  <= wc_next;
            wm1_reg <= XW'(wc_next - (XW+1)'(1));
            hm1_reg <= YW'(hc_next - (YW+1)'(1));
            // Stage 2: scale to texel space.
            la2_reg <= la1_reg;
            lt2_reg <= lt1_reg;
            tx_reg  <= (17+XW)'(uc_reg * wm1_reg);
            ty_reg  <= (17+YW)'(vc_reg * hm1_reg);
            wc2_reg <= wc_reg;
            // Stage 3: flat addresses and weights.
            la3_reg <= la2_reg;
            lt3_reg <= lt2_reg;
            a00_reg <= AW'(row0 + (AW+XW+1)'(x0));
            a10_reg <= AW'(row0 + (AW+XW+1)'(x1));
            a01_reg <= AW'(row1 + (AW+XW+1)'(x0));
            a11_reg <= AW'(row1 + (AW+XW+1)'(x1));
            fx_reg  <= fx_next;
            fy_reg  <= fy_next;
        end
    end

    assign out_ctl          = ctl3_reg;
    assign out_load_address = la3_reg;
    assign out_load_texel   = lt3_reg;
    assign a00              = a00_reg;
    assign a10              = a10_reg;
    assign a01              = a01_reg;
    assign a11              = a11_reg;
    assign fx               = fx_reg;
    assign fy               = fy_reg;

endmodule

/* src/bts_texmem.sv */
// ----------------------------------------------------------------------------
// bts_texmem: texel store
// Four copies of the texture, written together by loads, each read at one
// of the four corner addresses of a sample. Read data is registered.
// ----------------------------------------------------------------------------
module bts_texmem (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  bts_pkg::ctl_t    in_ctl,
    input  logic [15:0]      load_address,
    input  bts_pkg::texel_t  load_texel,
    input  bts_pkg::addr_t   a00,
    input  bts_pkg::addr_t   a10,
    input  bts_pkg::addr_t   a01,
    input  bts_pkg::addr_t   a11,
    input  logic [15:0]      fx,
    input  logic [15:0]      fy,
    output bts_pkg::ctl_t    out_ctl,
    output bts_pkg::texel_t  t00,
    output bts_pkg::texel_t  t10,
    output bts_pkg::texel_t  t01,
    output bts_pkg::texel_t  t11,
    output logic [15:0]      out_fx,
    output logic [15:0]      out_fy
);

    localparam int AW = bts_pkg::AW;

    bts_pkg::texel_t mem00 [bts_pkg::DEPTH];
    bts_pkg::texel_t mem10 [bts_pkg::DEPTH];
    bts_pkg::texel_t mem01 [bts_pkg::DEPTH];
    bts_pkg::texel_t mem11 [bts_pkg::DEPTH];

    bts_pkg::ctl_t   ctl_reg;
    bts_pkg::texel_t t00_reg, t10_reg, t01_reg, t11_reg;
    logic [15:0]     fx_reg, fy_reg;
    logic            wr;
    bts_pkg::addr_t  waddr;

    assign wr    = in_ctl.valid && !in_ctl.sample
                   && (32'(load_address) < bts_pkg::DEPTH);
    assign waddr = AW'(load_address);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= in_ctl;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (wr)
            begin
                mem00[waddr] <= load_texel;
                mem10[waddr] <= load_texel;
                mem01[waddr] <= load_texel;
                mem11[waddr] <= load_texel;
            end
            t00_reg <= mem00[a00];
            t10_reg <= mem10[a10];
            t01_reg <= mem01[a01];
            t11_reg <= mem11[a11];
            fx_reg  <= fx;
            fy_reg  <= fy;
        end
    end

    assign out_ctl = ctl_reg;
    assign t00     = t00_reg;
    assign t10     = t10_reg;
    assign t01     = t01_reg;
    assign t11     = t11_reg;
    assign out_fx  = fx_reg;
    assign out_fy  = fy_reg;

endmodule

/* src/bts_blend.sv */
// ----------------------------------------------------------------------------
// bts_blend: bilinear blend
// Row blends in one stage, the blend between rows and rounding in the next.
// ----------------------------------------------------------------------------
module bts_blend (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  bts_pkg::ctl_t    in_ctl,
    input  bts_pkg::texel_t  t00,
    input  bts_pkg::texel_t  t10,
    input  bts_pkg::texel_t  t01,
    input  bts_pkg::texel_t  t11,
    input  logic [15:0]      fx,
    input  logic [15:0]      fy,
    output bts_pkg::ctl_t    out_ctl,
    output bts_pkg::texel_t  texel
);

    bts_pkg::ctl_t ctl5_reg, ctl6_reg;
    logic [23:0]   top_reg [3];
    logic [23:0]   bot_reg [3];
    logic [15:0]   fy_reg;
    logic [23:0]   rgb_reg;

    logic [16:0]   wx0, wy0;
    logic [23:0]   top_next [3];
    logic [23:0]   bot_next [3];
    logic [39:0]   sum [3];
    logic [23:0]   rgb_next;

    always_comb
    begin
        wx0 = 17'(bts_pkg::ONE_FIX) - 17'(fx);
        wy0 = 17'(bts_pkg::ONE_FIX) - 17'(fy_reg);
        for (int k = 0; k < 3; k++)
        begin
            top_next[k] = 24'(t00[8*k +: 8] * wx0) + 24'(t10[8*k +: 8] * fx);
            bot_next[k] = 24'(t01[8*k +: 8] * wx0) + 24'(t11[8*k +: 8] * fx);
            sum[k]      = 40'(top_reg[k] * wy0) + 40'(bot_reg[k] * fy_reg)
                          + 40'h0080000000;
            rgb_next[8*k +: 8] = sum[k][39:32];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl5_reg <= '0;
            ctl6_reg <= '0;
        end
        else if (en)
        begin
            ctl5_reg <= in_ctl;
            ctl6_reg <= ctl5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            top_reg <= top_next;
            bot_reg <= bot_next;
            fy_reg  <= fy;
            rgb_reg <= rgb_next;
        end
    end

    assign out_ctl = ctl6_reg;
    assign texel   = rgb_reg;

endmodule
